>>> rtl/pmg_pkg.sv
// Shared widths, register map and limits for the point-mass gravity step.
// No dependencies; imported by the top level and the square-root pipeline.
package pmg_pkg;

  localparam int P_W     = 48;   // position / velocity word
  localparam int S_W     = 98;   // sum of squared separations
  localparam int R_W     = 50;   // integer square root
  localparam int U_W     = 33;   // unit vector component, 32 fraction bits
  localparam int U_FRAC  = 32;
  localparam int DT_W    = 32;
  localparam int DT_FRAC = 24;
  localparam int GM_W    = 63;
  localparam int RMIN_W  = 47;
  localparam int MAG_W   = 95;   // acceleration magnitude after clamp
  localparam int DV_W    = 51;   // velocity change magnitude after clamp
  localparam int CFG_AW  = 6;
  localparam int CFG_DW  = 64;

  localparam logic [MAG_W-1:0] MAG_MAX = '1;
  localparam logic [DV_W-1:0]  DV_LIM  = DV_W'(1) << (DV_W - 1);
  localparam logic [P_W-1:0]   MAX48   = {1'b0, {(P_W-1){1'b1}}};
  localparam logic [P_W-1:0]   MIN48   = {1'b1, {(P_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_GM   = 3'd0,
    REG_HX   = 3'd1,
    REG_HY   = 3'd2,
    REG_HZ   = 3'd3,
    REG_DT   = 3'd4,
    REG_RMIN = 3'd5
  } reg_idx_t;

endpackage

>>> rtl/pmg_udiv.sv
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across LANES numerators. Standalone; used twice by the top level.
module pmg_udiv #(
  parameter int LANES = 1,
  parameter int QW    = 8,
  parameter int RW    = 8,
  parameter int SW    = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][RW-1:0]    rem_in,
  input  logic [LANES-1:0][QW-1:0]    num_in,
  input  logic [RW-1:0]               den_in,
  input  logic [SW-1:0]               side_in,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    quo_out,
  output logic [SW-1:0]               side_out
);

  logic                        vld_r  [QW];
  logic [LANES-1:0][RW-1:0]    rem_r  [QW];
  logic [LANES-1:0][QW-1:0]    num_r  [QW];
  logic [LANES-1:0][QW-1:0]    quo_r  [QW];
  logic [RW-1:0]               den_r  [QW];
  logic [SW-1:0]               side_r [QW];

  logic                        vld_nxt  [QW];
  logic [LANES-1:0][RW-1:0]    rem_nxt  [QW];
  logic [LANES-1:0][QW-1:0]    num_nxt  [QW];
  logic [LANES-1:0][QW-1:0]    quo_nxt  [QW];
  logic [RW-1:0]               den_nxt  [QW];
  logic [SW-1:0]               side_nxt [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic                     v_p;
    logic [LANES-1:0][RW-1:0] rem_p;
    logic [LANES-1:0][QW-1:0] num_p;
    logic [LANES-1:0][QW-1:0] quo_p;
    logic [RW-1:0]            den_p;
    logic [SW-1:0]            side_p;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = rem_in;
      assign num_p  = num_in;
      assign quo_p  = '0;
      assign den_p  = den_in;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign num_p  = num_r[k-1];
      assign quo_p  = quo_r[k-1];
      assign den_p  = den_r[k-1];
      assign side_p = side_r[k-1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW:0] rem2;
      logic [RW:0] diff;
      logic        ge;
      assign rem2 = {rem_p[l], num_p[l][QW-1-k]};
      assign diff = rem2 - {1'b0, den_p};
      assign ge   = rem2 >= {1'b0, den_p};
      assign rem_nxt[k][l] = ge ? diff[RW-1:0] : rem2[RW-1:0];
      assign quo_nxt[k][l] = (quo_p[l] << 1) | QW'(ge);
    end

    assign vld_nxt[k]  = v_p;
    assign num_nxt[k]  = num_p;
    assign den_nxt[k]  = den_p;
    assign side_nxt[k] = side_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < QW; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QW; k++) vld_r[k] <= vld_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_r[k]  <= rem_nxt[k];
        num_r[k]  <= num_nxt[k];
        quo_r[k]  <= quo_nxt[k];
        den_r[k]  <= den_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign quo_out   = quo_r[QW-1];
  assign side_out  = side_r[QW-1];

endmodule

>>> rtl/pmg_isqrt.sv
// Pipelined integer square root, one root bit (two radicand bits) per stage.
// Depends on pmg_pkg for the radicand and root widths.
module pmg_isqrt
  import pmg_pkg::*;
#(
  parameter int SW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [S_W-1:0]   sq_in,
  input  logic [SW-1:0]    side_in,
  output logic             out_valid,
  output logic [R_W-1:0]   root_out,
  output logic [SW-1:0]    side_out
);

  localparam int RAD_W = 2 * R_W;
  localparam int REM_W = R_W + 1;

  logic               vld_r  [R_W];
  logic [RAD_W-1:0]   rad_r  [R_W];
  logic [REM_W-1:0]   rem_r  [R_W];
  logic [R_W-1:0]     root_r [R_W];
  logic [SW-1:0]      side_r [R_W];

  logic               vld_nxt  [R_W];
  logic [RAD_W-1:0]   rad_nxt  [R_W];
  logic [REM_W-1:0]   rem_nxt  [R_W];
  logic [R_W-1:0]     root_nxt [R_W];
  logic [SW-1:0]      side_nxt [R_W];

  for (genvar k = 0; k < R_W; k++) begin : g_st
    logic             v_p;
    logic [RAD_W-1:0] rad_p;
    logic [REM_W-1:0] rem_p;
    logic [R_W-1:0]   root_p;
    logic [SW-1:0]    side_p;
    logic [REM_W+1:0] rem2;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rad_p  = RAD_W'(sq_in);
      assign rem_p  = '0;
      assign root_p = '0;
      assign side_p = side_in;
    end else begin : g_next
      assign v_p    = vld_r[k-1];
      assign rad_p  = rad_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign side_p = side_r[k-1];
    end

    // remainder stays at most twice the partial root
    assign rem2  = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign diff  = rem2 - trial;
    assign ge    = rem2 >= trial;

    assign vld_nxt[k]  = v_p;
    assign rad_nxt[k]  = rad_p << 2;
    assign rem_nxt[k]  = ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
    assign root_nxt[k] = {root_p[R_W-2:0], ge};
    assign side_nxt[k] = side_p;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < R_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < R_W; k++) vld_r[k] <= vld_nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < R_W; k++) begin
        rad_r[k]  <= rad_nxt[k];
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        side_r[k] <= side_nxt[k];
      end
    end
  end

  assign out_valid = vld_r[R_W-1];
  assign root_out  = root_r[R_W-1];
  assign side_out  = side_r[R_W-1];

endmodule

>>> rtl/point_mass_gravity_euler_step.sv
// Top level: one semi-implicit Euler step of a particle under point-mass gravity.
// Depends on pmg_pkg, pmg_isqrt and pmg_udiv.
//
// Usage:
//   in_*  : one particle word per handshake (position and velocity, 48-bit signed,
//           FRAC_BITS fraction bits). Every input word gives one output word.
//   out_* : updated position and velocity; tuser carries saturated and too_close.
//   cfg_* : register file (gravity parameter, point mass position, time step,
//           minimum radius) at byte address 8*index; write only while idle.
// Throughput: one word per cycle while in_tready is high. The path from input
//   handshake to out_tvalid runs through the 50-stage square root, the
//   33-stage unit vector divider and the (63 + 2*FRAC_BITS)-stage magnitude
//   divider, plus 14 arithmetic and output stages.
// Reset: registers take their reset values (min_radius = 1, others 0) and the
//   pipeline empties; words in flight are dropped.
// Stall: a two-word output buffer sits after the pipeline. The pipeline keeps
//   moving until that buffer is full, then freezes as a whole; in_tready drops
//   only while both buffer words wait to be taken.
module point_mass_gravity_euler_step
  import pmg_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [287:0]      in_tdata,    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [287:0]      out_tdata,   // new_pos_x/y/z, new_vel_x/y/z
  output logic [1:0]        out_tuser,   // saturated, too_close
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int MQW = GM_W + 2 * FRAC_BITS;
  localparam int MXW = (MQW > MAG_W) ? MQW : MAG_W;

  typedef logic [2:0][P_W-1:0] vec_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    vec_t           ad;
    logic [2:0]     sg;
    vec_t           pos;
    vec_t           vel;
  } sq_side_t;

  typedef struct packed {
    logic [S_W-1:0] s;
    logic           close;
    logic [2:0]     sg;
    vec_t           pos;
    vec_t           vel;
  } ud_side_t;

  typedef struct packed {
    logic [2:0][U_W-1:0] u;
    logic                close;
    logic [2:0]          sg;
    vec_t                pos;
    vec_t                vel;
  } md_side_t;

  typedef struct packed {
    vec_t vel;
    vec_t pos;
    logic close;
    logic sat;
  } res_t;

  // ---------------- configuration ----------------
  logic [GM_W-1:0]   gm_r;
  logic [P_W-1:0]    hx_r, hy_r, hz_r;
  logic [DT_W-1:0]   dt_r;
  logic [RMIN_W-1:0] rmin_r;
  logic              cfg_we;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gm_r   <= '0;
      hx_r   <= '0;
      hy_r   <= '0;
      hz_r   <= '0;
      dt_r   <= '0;
      rmin_r <= RMIN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_paddr[CFG_AW-1:3])
        REG_GM:   gm_r   <= cfg_pwdata[GM_W-1:0];
        REG_HX:   hx_r   <= cfg_pwdata[P_W-1:0];
        REG_HY:   hy_r   <= cfg_pwdata[P_W-1:0];
        REG_HZ:   hz_r   <= cfg_pwdata[P_W-1:0];
        REG_DT:   dt_r   <= cfg_pwdata[DT_W-1:0];
        REG_RMIN: rmin_r <= cfg_pwdata[RMIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[CFG_AW-1:3])
      REG_GM:   cfg_prdata = CFG_DW'(gm_r);
      REG_HX:   cfg_prdata = CFG_DW'(hx_r);
      REG_HY:   cfg_prdata = CFG_DW'(hy_r);
      REG_HZ:   cfg_prdata = CFG_DW'(hz_r);
      REG_DT:   cfg_prdata = CFG_DW'(dt_r);
      REG_RMIN: cfg_prdata = CFG_DW'(rmin_r);
      default:  cfg_prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [1:0] cnt_r;
  logic       en;
  logic       push;
  logic       pop;

  assign en        = (cnt_r != 2'd2);
  assign in_tready = en;

  // ---------------- stage 1: separation ----------------
  vec_t       pos_in, vel_in, hole;
  vec_t       ad_s1;
  logic [2:0] sg_s1;

  assign pos_in = in_tdata[143:0];
  assign vel_in = in_tdata[287:144];
  assign hole   = {hz_r, hy_r, hx_r};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [P_W:0] d;
      d        = {hole[i][P_W-1], hole[i]} - {pos_in[i][P_W-1], pos_in[i]};
      sg_s1[i] = d[P_W];
      ad_s1[i] = d[P_W] ? P_W'(-d) : d[P_W-1:0];
    end
  end

  logic       v1_r, v2_r, v3_r, v4_r;
  vec_t       pos1_r, vel1_r, ad1_r, pos2_r, vel2_r, ad2_r;
  vec_t       pos3_r, vel3_r, ad3_r, pos4_r, vel4_r, ad4_r;
  logic [2:0] sg1_r, sg2_r, sg3_r, sg4_r;
  logic [2:0][47:0] hh2_r, hl2_r, ll2_r;
  logic [2:0][95:0] sq3_r;
  logic [S_W-1:0]   s4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pos1_r <= pos_in;  vel1_r <= vel_in;  ad1_r <= ad_s1;  sg1_r <= sg_s1;
      // squares split into 24-bit halves
      for (int i = 0; i < 3; i++) begin
        hh2_r[i] <= 48'(ad1_r[i][47:24]) * 48'(ad1_r[i][47:24]);
        hl2_r[i] <= 48'(ad1_r[i][47:24]) * 48'(ad1_r[i][23:0]);
        ll2_r[i] <= 48'(ad1_r[i][23:0]) * 48'(ad1_r[i][23:0]);
        sq3_r[i] <= (96'(hh2_r[i]) << 48) + (96'(hl2_r[i]) << 25) + 96'(ll2_r[i]);
      end
      pos2_r <= pos1_r;  vel2_r <= vel1_r;  ad2_r <= ad1_r;  sg2_r <= sg1_r;
      pos3_r <= pos2_r;  vel3_r <= vel2_r;  ad3_r <= ad2_r;  sg3_r <= sg2_r;
      s4_r   <= S_W'(sq3_r[0]) + S_W'(sq3_r[1]) + S_W'(sq3_r[2]);
      pos4_r <= pos3_r;  vel4_r <= vel3_r;  ad4_r <= ad3_r;  sg4_r <= sg3_r;
    end
  end

  // ---------------- square root ----------------
  sq_side_t       sq_side_in, sq_side_out;
  logic           sq_v;
  logic [R_W-1:0] root;

  assign sq_side_in = '{s: s4_r, ad: ad4_r, sg: sg4_r, pos: pos4_r, vel: vel4_r};

  pmg_isqrt #(.SW($bits(sq_side_t))) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .sq_in     (s4_r),
    .side_in   (sq_side_in),
    .out_valid (sq_v),
    .root_out  (root),
    .side_out  (sq_side_out)
  );

  // ---------------- unit vector ----------------
  logic [2:0][R_W-1:0] ud_rem;
  logic [2:0][U_W-1:0] ud_num;
  logic [2:0][U_W-1:0] ud_quo;
  ud_side_t            ud_side_in, ud_side_out;
  logic                ud_v;
  logic                close_sq;

  assign close_sq = (root == '0) || (root < R_W'(rmin_r));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      // top quotient bits are known zero since |d| <= r
      ud_rem[i] = R_W'(sq_side_out.ad[i] >> 1);
      ud_num[i] = {sq_side_out.ad[i][0], {U_FRAC{1'b0}}};
    end
  end

  assign ud_side_in = '{s: sq_side_out.s, close: close_sq, sg: sq_side_out.sg,
                        pos: sq_side_out.pos, vel: sq_side_out.vel};

  pmg_udiv #(.LANES(3), .QW(U_W), .RW(R_W), .SW($bits(ud_side_t))) u_unit_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_v),
    .rem_in    (ud_rem),
    .num_in    (ud_num),
    .den_in    (root),
    .side_in   (ud_side_in),
    .out_valid (ud_v),
    .quo_out   (ud_quo),
    .side_out  (ud_side_out)
  );

  // ---------------- acceleration magnitude ----------------
  logic [0:0][S_W-1:0] md_rem;
  logic [0:0][MQW-1:0] md_num;
  logic [0:0][MQW-1:0] md_quo;
  md_side_t            md_side_in, md_side_out;
  logic                md_v;

  assign md_rem[0]  = '0;
  assign md_num[0]  = MQW'(gm_r) << (2 * FRAC_BITS);
  assign md_side_in = '{u: ud_quo, close: ud_side_out.close, sg: ud_side_out.sg,
                        pos: ud_side_out.pos, vel: ud_side_out.vel};

  pmg_udiv #(.LANES(1), .QW(MQW), .RW(S_W), .SW($bits(md_side_t))) u_mag_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ud_v),
    .rem_in    (md_rem),
    .num_in    (md_num),
    .den_in    (ud_side_out.s),
    .side_in   (md_side_in),
    .out_valid (md_v),
    .quo_out   (md_quo),
    .side_out  (md_side_out)
  );

  // ---------------- velocity change ----------------
  logic [MXW-1:0]   mag_x;
  logic             msat;
  logic [MAG_W-1:0] magc;

  assign mag_x = MXW'(md_quo[0]);
  assign msat  = mag_x > MXW'(MAG_MAX);
  assign magc  = msat ? MAG_MAX : mag_x[MAG_W-1:0];

  logic       v5_r, v6_r, v7_r, v8_r, v9_r, v10_r, v11_r, v12_r, v13_r;
  logic [2:0][63:0] pm5_r;
  logic [126:0]     sum6_r;
  logic [MAG_W-1:0] dvm7_r, dvm8_r;
  logic [2:0][2:0][63:0] cp8_r;
  logic [2:0]       u32_8_r;
  logic [2:0][95:0] c9_r;
  logic [2:0][51:0] dv10_r;
  logic [2:0][U_W-1:0] u5_r, u6_r, u7_r;
  logic             sat5_r, sat6_r, sat7_r, sat8_r, sat9_r, sat10_r, sat11_r;
  logic             sat12_r, sat13_r;
  logic             cl5_r, cl6_r, cl7_r, cl8_r, cl9_r, cl10_r, cl11_r, cl12_r, cl13_r;
  logic [2:0]       sg5_r, sg6_r, sg7_r, sg8_r, sg9_r;
  vec_t pos5_r, pos6_r, pos7_r, pos8_r, pos9_r, pos10_r, pos11_r, pos12_r, pos13_r;
  vec_t vel5_r, vel6_r, vel7_r, vel8_r, vel9_r, vel10_r;
  vec_t nv11_r, nv12_r, nv13_r, nabs11_r;
  logic [2:0]       neg11_r, neg12_r, neg13_r;
  logic [2:0][55:0] nh12_r, nl12_r, dpm13_r;

  logic [102:0] dvm_sh;
  logic         dsat;
  assign dvm_sh = sum6_r[126:DT_FRAC];
  assign dsat   = |dvm_sh[102:MAG_W];

  logic [2:0][95:0]     c_nxt;
  logic [2:0][51:0]     dv_nxt;
  logic [2:0]           csat;
  vec_t                 nv_nxt, nabs_nxt;
  logic [2:0]           vsat;
  logic [2:0][55:0]     dpm_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [127:0]    csum;
      logic [DV_W-1:0] cm;
      logic [52:0]     vs;
      logic [79:0]     dp_full;
      csum = 128'(cp8_r[i][0]) + (128'(cp8_r[i][1]) << 32) + (128'(cp8_r[i][2]) << 64);
      // u of exactly one leaves the magnitude unchanged
      c_nxt[i]  = u32_8_r[i] ? 96'(dvm8_r) : csum[127:U_FRAC];
      csat[i]   = c9_r[i] > 96'(DV_LIM);
      cm        = csat[i] ? DV_LIM : c9_r[i][DV_W-1:0];
      dv_nxt[i] = cl9_r ? '0 : (sg9_r[i] ? -52'(cm) : 52'(cm));
      vs        = {{5{vel10_r[i][P_W-1]}}, vel10_r[i]} + {dv10_r[i][51], dv10_r[i]};
      vsat[i]   = (vs[52:47] != 6'h00) && (vs[52:47] != 6'h3f);
      nv_nxt[i] = !vsat[i] ? vs[47:0] : (vs[52] ? MIN48 : MAX48);
      nabs_nxt[i] = nv_nxt[i][P_W-1] ? P_W'(-nv_nxt[i]) : nv_nxt[i];
      dp_full    = (80'(nh12_r[i]) << 24) + 80'(nl12_r[i]);
      dpm_nxt[i] = dp_full[79:DT_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 5: clamp magnitude, times dt in 32-bit slices
      pm5_r[0] <= 64'(magc[31:0])  * 64'(dt_r);
      pm5_r[1] <= 64'(magc[63:32]) * 64'(dt_r);
      pm5_r[2] <= 64'(magc[94:64]) * 64'(dt_r);
      sat5_r <= msat;  cl5_r <= md_side_out.close;  sg5_r <= md_side_out.sg;
      u5_r <= md_side_out.u;  pos5_r <= md_side_out.pos;  vel5_r <= md_side_out.vel;
      // stage 6
      sum6_r <= 127'(pm5_r[0]) + (127'(pm5_r[1]) << 32) + (127'(pm5_r[2]) << 64);
      sat6_r <= sat5_r;  cl6_r <= cl5_r;  sg6_r <= sg5_r;  u6_r <= u5_r;
      pos6_r <= pos5_r;  vel6_r <= vel5_r;
      // stage 7
      dvm7_r <= dsat ? MAG_MAX : dvm_sh[MAG_W-1:0];
      sat7_r <= sat6_r | dsat;  cl7_r <= cl6_r;  sg7_r <= sg6_r;  u7_r <= u6_r;
      pos7_r <= pos6_r;  vel7_r <= vel6_r;
      // stage 8: magnitude times unit vector
      for (int i = 0; i < 3; i++) begin
        cp8_r[i][0] <= 64'(dvm7_r[31:0])  * 64'(u7_r[i][31:0]);
        cp8_r[i][1] <= 64'(dvm7_r[63:32]) * 64'(u7_r[i][31:0]);
        cp8_r[i][2] <= 64'(dvm7_r[94:64]) * 64'(u7_r[i][31:0]);
        u32_8_r[i]  <= u7_r[i][U_W-1];
      end
      dvm8_r <= dvm7_r;  sat8_r <= sat7_r;  cl8_r <= cl7_r;  sg8_r <= sg7_r;
      pos8_r <= pos7_r;  vel8_r <= vel7_r;
      // stage 9
      c9_r <= c_nxt;  sat9_r <= sat8_r;  cl9_r <= cl8_r;  sg9_r <= sg8_r;
      pos9_r <= pos8_r;  vel9_r <= vel8_r;
      // stage 10: internal flags count only when acceleration applies
      dv10_r  <= dv_nxt;
      sat10_r <= !cl9_r && (sat9_r || (|csat));
      cl10_r  <= cl9_r;  pos10_r <= pos9_r;  vel10_r <= vel9_r;
      // stage 11: new velocity
      nv11_r <= nv_nxt;  nabs11_r <= nabs_nxt;
      for (int i = 0; i < 3; i++) neg11_r[i] <= nv_nxt[i][P_W-1];
      sat11_r <= sat10_r | (|vsat);  cl11_r <= cl10_r;  pos11_r <= pos10_r;
      // stage 12: |v'| times dt in halves
      for (int i = 0; i < 3; i++) begin
        nh12_r[i] <= 56'(nabs11_r[i][47:24]) * 56'(dt_r);
        nl12_r[i] <= 56'(nabs11_r[i][23:0])  * 56'(dt_r);
      end
      nv12_r <= nv11_r;  neg12_r <= neg11_r;  sat12_r <= sat11_r;  cl12_r <= cl11_r;
      pos12_r <= pos11_r;
      // stage 13
      dpm13_r <= dpm_nxt;  nv13_r <= nv12_r;  neg13_r <= neg12_r;
      sat13_r <= sat12_r;  cl13_r <= cl12_r;  pos13_r <= pos12_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;  v2_r <= 1'b0;  v3_r <= 1'b0;  v4_r <= 1'b0;
      v5_r <= 1'b0;  v6_r <= 1'b0;  v7_r <= 1'b0;  v8_r <= 1'b0;
      v9_r <= 1'b0;  v10_r <= 1'b0; v11_r <= 1'b0; v12_r <= 1'b0; v13_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;  v2_r <= v1_r;  v3_r <= v2_r;  v4_r <= v3_r;
      v5_r <= md_v;  v6_r <= v5_r;  v7_r <= v6_r;  v8_r <= v7_r;
      v9_r <= v8_r;  v10_r <= v9_r;  v11_r <= v10_r; v12_r <= v11_r; v13_r <= v12_r;
    end
  end

  // ---------------- stage 14: new position ----------------
  res_t res;
  logic [2:0] psat;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [57:0] dp;
      logic [57:0] ps;
      dp = neg13_r[i] ? -58'(dpm13_r[i]) : 58'(dpm13_r[i]);
      ps = {{10{pos13_r[i][P_W-1]}}, pos13_r[i]} + dp;
      psat[i]    = (ps[57:47] != 11'h000) && (ps[57:47] != 11'h7ff);
      res.pos[i] = !psat[i] ? ps[47:0] : (ps[57] ? MIN48 : MAX48);
    end
    res.vel   = nv13_r;
    res.close = cl13_r;
    res.sat   = sat13_r | (|psat);
  end

  // ---------------- output buffer, two words ----------------
  res_t ent_r [2];
  logic wp_r, rp_r;

  assign push = v13_r && en;
  assign pop  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= res;
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = {ent_r[rp_r].vel, ent_r[rp_r].pos};
  assign out_tuser  = {ent_r[rp_r].close, ent_r[rp_r].sat};

  // ---------------- assertions ----------------
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> cnt_r != 2'd2)
    else $error("word pushed into a full output buffer");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v13_r) && $stable(md_v))
    else $error("pipeline moved while stalled");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    pop && !push |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("buffer count lost a word");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_tvalid)
    else $error("pushed word not presented");

endmodule
